>>> rtl/assert_macros.svh
// assertion helpers, all disabled while reset is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/srsi_pkg.sv
package srsi_pkg;

    localparam int RSI_W      = 15;
    localparam int MAX_K      = 64;
    localparam int MAX_SMOOTH = 16;
    localparam int MAX_D      = 16;
    localparam int ADDR_W     = $clog2(MAX_K);
    localparam int HIDX_W     = $clog2(MAX_SMOOTH);
    localparam int KP_W       = 7;
    localparam int SM_W       = 5;
    localparam int CNT_W      = 8;
    localparam int HIST_W     = RSI_W + 1;
    localparam int SUM_W      = RSI_W + HIDX_W;
    localparam int DIVD_W     = 2 * RSI_W;
    localparam int DCNT_W     = 4;

    localparam logic [RSI_W-1:0] FULL_SCALE = RSI_W'(25600);
    localparam logic [RSI_W-1:0] RSI_MAXV   = '1;

    typedef enum logic [1:0] {
        REG_K_PERIOD = 2'd0,
        REG_K_SMOOTH = 2'd1,
        REG_D_PERIOD = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [RSI_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [RSI_W-1:0] quotient;
    } div_resp_t;

endpackage

>>> rtl/srsi_ring.sv
module srsi_ring
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [srsi_pkg::ADDR_W-1:0] wr_addr,
    input  logic [srsi_pkg::RSI_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [srsi_pkg::ADDR_W-1:0] rd_addr,
    output logic [srsi_pkg::RSI_W-1:0]  rd_data
);

    logic [srsi_pkg::RSI_W-1:0] mem [srsi_pkg::MAX_K];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/srsi_div.sv
module srsi_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  srsi_pkg::div_req_t  req,
    output srsi_pkg::div_resp_t resp
);

    logic [srsi_pkg::RSI_W-1:0]  rem_reg, rem_next;
    logic [srsi_pkg::RSI_W-1:0]  lowq_reg, lowq_next;
    logic [srsi_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic [srsi_pkg::RSI_W:0]    trial;
    logic [srsi_pkg::RSI_W:0]    diff;

    // one quotient bit a cycle, restoring
    always_comb
    begin
        trial     = {rem_reg, lowq_reg[srsi_pkg::RSI_W-1]};
        diff      = trial - {1'b0, req.divisor};
        rem_next  = rem_reg;
        lowq_next = lowq_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.dividend[srsi_pkg::DIVD_W-1:srsi_pkg::RSI_W];
            lowq_next = req.dividend[srsi_pkg::RSI_W-1:0];
            cnt_next  = srsi_pkg::DCNT_W'(srsi_pkg::RSI_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[srsi_pkg::RSI_W])
            begin
                rem_next  = diff[srsi_pkg::RSI_W-1:0];
                lowq_next = {lowq_reg[srsi_pkg::RSI_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[srsi_pkg::RSI_W-1:0];
                lowq_next = {lowq_reg[srsi_pkg::RSI_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == srsi_pkg::DCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        lowq_reg <= lowq_next;
    end

    assign resp.done     = done_reg;
    assign resp.quotient = lowq_reg;

endmodule

>>> rtl/stochastic_rsi_oscillator_top.sv
// stochastic rsi oscillator: one rsi sample (unsigned q7.8) per input item gives one
// result item carrying %k, %d and their valid flags. items are handled one at a time;
// s_axis_tready is high only while the sequencer is idle. the scan of the sample ring
// for high and low is pipelined, one ring read a cycle. each pass through the shared
// serial divider (stoch ratio, %k mean, %d mean) runs load, 15 quotient bits, done; the
// stoch division is skipped when warm-up or a flat window leaves no valid ratio. the
// history sums take one entry a cycle. the result waits in an output register, so the
// next item is taken while it is still pending; a new result that finds the register
// still full waits until m_axis_tready is high. registers sit at byte addresses 0
// (window length), 4 (%k smoothing length) and 8 (%d length); zero is taken as one and
// values above the maximum are clamped, read back gives the stored value before clamping.
`include "assert_macros.svh"

module stochastic_rsi_oscillator_top
(
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [14:0] rsi_value
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [14:0] stoch_k, [29:15] stoch_d
    output logic [1:0]  m_axis_tuser    // [0] k_valid, [1] d_valid
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SDIV, S_KSUM, S_KDIV, S_DSUM, S_DDIV, S_OUT
    } state_t;

    localparam int RW = srsi_pkg::RSI_W;

    state_t state_reg, state_next;

    // configuration registers
    logic [srsi_pkg::KP_W-1:0] kper_reg;
    logic [srsi_pkg::SM_W-1:0] ksm_reg;
    logic [srsi_pkg::SM_W-1:0] dper_reg;

    // per-item working registers
    logic [srsi_pkg::ADDR_W-1:0] wp_reg, wp_next;
    logic [srsi_pkg::ADDR_W-1:0] wpi_reg, wpi_next;
    logic [srsi_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [srsi_pkg::KP_W-1:0]   kp_reg, kp_next;
    logic [srsi_pkg::SM_W-1:0]   ks_reg, ks_next;
    logic [srsi_pkg::SM_W-1:0]   dp_reg, dp_next;
    logic [RW-1:0]               rsi_reg, rsi_next;
    logic [RW-1:0]               hi_reg, hi_next;
    logic [RW-1:0]               lo_reg, lo_next;
    logic [srsi_pkg::KP_W-1:0]   iss_reg, iss_next;
    logic                        pend_reg, pend_next;
    logic [srsi_pkg::HIDX_W-1:0] idx_reg, idx_next;
    logic [srsi_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic                        ok_reg, ok_next;
    logic                        kok_reg, kok_next;
    logic [RW-1:0]               kval_reg, kval_next;
    logic                        go_reg, go_next;

    // histories, index 0 newest
    logic [srsi_pkg::HIST_W-1:0] sh_reg [srsi_pkg::MAX_SMOOTH];
    logic [srsi_pkg::HIST_W-1:0] kh_reg [srsi_pkg::MAX_D];
    logic                        spush, kpush;
    logic [srsi_pkg::HIST_W-1:0] spush_val, kpush_val;

    // output register
    logic          ov_reg, ov_next;
    logic [31:0]   od_reg, od_next;
    logic [1:0]    ou_reg, ou_next;

    logic                   in_acc;
    logic                   cfg_wr;
    logic                   rd_en;
    logic [srsi_pkg::ADDR_W-1:0] rd_addr;
    logic [RW-1:0]          rd_data;
    logic [srsi_pkg::KP_W-1:0] kp_cl;
    logic [srsi_pkg::SM_W-1:0] ks_cl, dp_cl;
    logic [srsi_pkg::HIST_W-1:0] hsel;
    logic [RW-1:0]          span;
    logic [srsi_pkg::DIVD_W-1:0] prod;

    srsi_pkg::div_req_t  div_req;
    srsi_pkg::div_resp_t div_resp;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            srsi_pkg::REG_K_PERIOD: prdata = {25'd0, kper_reg};
            srsi_pkg::REG_K_SMOOTH: prdata = {27'd0, ksm_reg};
            srsi_pkg::REG_D_PERIOD: prdata = {27'd0, dper_reg};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kper_reg <= srsi_pkg::KP_W'(14);
            ksm_reg  <= srsi_pkg::SM_W'(3);
            dper_reg <= srsi_pkg::SM_W'(3);
        end
        else if (cfg_wr && paddr[1:0] == 2'd0)
        begin
            case (paddr[3:2])
                srsi_pkg::REG_K_PERIOD: kper_reg <= pwdata[srsi_pkg::KP_W-1:0];
                srsi_pkg::REG_K_SMOOTH: ksm_reg  <= pwdata[srsi_pkg::SM_W-1:0];
                srsi_pkg::REG_D_PERIOD: dper_reg <= pwdata[srsi_pkg::SM_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped register values
    always_comb
    begin
        if (kper_reg == '0)
            kp_cl = srsi_pkg::KP_W'(1);
        else if (kper_reg > srsi_pkg::KP_W'(srsi_pkg::MAX_K))
            kp_cl = srsi_pkg::KP_W'(srsi_pkg::MAX_K);
        else
            kp_cl = kper_reg;
        if (ksm_reg == '0)
            ks_cl = srsi_pkg::SM_W'(1);
        else if (ksm_reg > srsi_pkg::SM_W'(srsi_pkg::MAX_SMOOTH))
            ks_cl = srsi_pkg::SM_W'(srsi_pkg::MAX_SMOOTH);
        else
            ks_cl = ksm_reg;
        if (dper_reg == '0)
            dp_cl = srsi_pkg::SM_W'(1);
        else if (dper_reg > srsi_pkg::SM_W'(srsi_pkg::MAX_D))
            dp_cl = srsi_pkg::SM_W'(srsi_pkg::MAX_D);
        else
            dp_cl = dper_reg;
    end

    srsi_ring u_ring
    (
        .clk     (clk),
        .wr_en   (in_acc),
        .wr_addr (wp_reg),
        .wr_data (s_axis_tdata[RW-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    srsi_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    // scan reads walk back from the newest slot
    assign rd_en   = (state_reg == S_SCAN) && (iss_reg < kp_reg);
    assign rd_addr = wpi_reg - iss_reg[srsi_pkg::ADDR_W-1:0];

    assign hsel = (state_reg == S_DSUM) ? kh_reg[idx_reg] : sh_reg[idx_reg];
    assign span = hi_reg - lo_reg;
    assign prod = srsi_pkg::DIVD_W'(srsi_pkg::FULL_SCALE) * srsi_pkg::DIVD_W'(rsi_reg - lo_reg);

    // divider operands follow the phase
    always_comb
    begin
        div_req.start = go_reg;
        case (state_reg)
            S_SDIV:
            begin
                div_req.dividend = prod;
                div_req.divisor  = span;
            end
            S_KDIV:
            begin
                div_req.dividend = srsi_pkg::DIVD_W'(sum_reg);
                div_req.divisor  = RW'(ks_reg);
            end
            default:
            begin
                div_req.dividend = srsi_pkg::DIVD_W'(sum_reg);
                div_req.divisor  = RW'(dp_reg);
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        wpi_next   = wpi_reg;
        cnt_next   = cnt_reg;
        kp_next    = kp_reg;
        ks_next    = ks_reg;
        dp_next    = dp_reg;
        rsi_next   = rsi_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        iss_next   = iss_reg;
        pend_next  = 1'b0;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        ok_next    = ok_reg;
        kok_next   = kok_reg;
        kval_next  = kval_reg;
        go_next    = 1'b0;
        ov_next    = ov_reg;
        od_next    = od_reg;
        ou_next    = ou_reg;
        spush      = 1'b0;
        spush_val  = '0;
        kpush      = 1'b0;
        kpush_val  = '0;

        if (ov_reg && m_axis_tready)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    wpi_next = wp_reg;
                    wp_next  = wp_reg + 1'b1;
                    if (cnt_reg < srsi_pkg::CNT_W'(srsi_pkg::MAX_K))
                        cnt_next = cnt_reg + 1'b1;
                    kp_next    = kp_cl;
                    ks_next    = ks_cl;
                    dp_next    = dp_cl;
                    rsi_next   = s_axis_tdata[RW-1:0];
                    hi_next    = '0;
                    lo_next    = srsi_pkg::RSI_MAXV;
                    iss_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                pend_next = rd_en;
                if (rd_en)
                    iss_next = iss_reg + 1'b1;
                if (pend_reg)
                begin
                    if (rd_data > hi_reg)
                        hi_next = rd_data;
                    if (rd_data < lo_reg)
                        lo_next = rd_data;
                end
                if (!rd_en && !pend_reg)
                begin
                    idx_next = '0;
                    sum_next = '0;
                    ok_next  = 1'b1;
                    if (cnt_reg >= srsi_pkg::CNT_W'(kp_reg) && hi_reg != lo_reg)
                    begin
                        go_next    = 1'b1;
                        state_next = S_SDIV;
                    end
                    else
                    begin
                        // warm-up or flat window: invalid zero entry
                        spush      = 1'b1;
                        state_next = S_KSUM;
                    end
                end
            end
            S_SDIV:
            begin
                if (div_resp.done)
                begin
                    spush      = 1'b1;
                    spush_val  = {1'b1, div_resp.quotient};
                    state_next = S_KSUM;
                end
            end
            S_KSUM, S_DSUM:
            begin
                sum_next = sum_reg + srsi_pkg::SUM_W'(hsel[RW-1:0]);
                ok_next  = ok_reg && hsel[RW];
                idx_next = idx_reg + 1'b1;
                if (state_reg == S_KSUM)
                begin
                    if (idx_reg == srsi_pkg::HIDX_W'(ks_reg - 1'b1))
                    begin
                        go_next    = 1'b1;
                        state_next = S_KDIV;
                    end
                end
                else if (idx_reg == srsi_pkg::HIDX_W'(dp_reg - 1'b1))
                begin
                    go_next    = 1'b1;
                    state_next = S_DDIV;
                end
            end
            S_KDIV:
            begin
                if (div_resp.done)
                begin
                    kok_next   = ok_reg;
                    kval_next  = ok_reg ? div_resp.quotient : '0;
                    kpush      = 1'b1;
                    kpush_val  = ok_reg ? {1'b1, div_resp.quotient} : '0;
                    idx_next   = '0;
                    sum_next   = '0;
                    ok_next    = 1'b1;
                    state_next = S_DSUM;
                end
            end
            S_DDIV:
            begin
                // the divider holds the %d quotient until its next start
                if (div_resp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hand over once the output register is free
                if (!ov_reg || m_axis_tready)
                begin
                    od_next    = {2'b00, (ok_reg ? div_resp.quotient : RW'(0)), kval_reg};
                    ou_next    = {ok_reg, kok_reg};
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            go_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < srsi_pkg::MAX_SMOOTH; i++)
            begin
                sh_reg[i] <= '0;
            end
            for (int i = 0; i < srsi_pkg::MAX_D; i++)
            begin
                kh_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            go_reg    <= go_next;
            ov_reg    <= ov_next;
            if (spush)
            begin
                for (int i = srsi_pkg::MAX_SMOOTH - 1; i > 0; i--)
                begin
                    sh_reg[i] <= sh_reg[i-1];
                end
                sh_reg[0] <= spush_val;
            end
            if (kpush)
            begin
                for (int i = srsi_pkg::MAX_D - 1; i > 0; i--)
                begin
                    kh_reg[i] <= kh_reg[i-1];
                end
                kh_reg[0] <= kpush_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wpi_reg  <= wpi_next;
        kp_reg   <= kp_next;
        ks_reg   <= ks_next;
        dp_reg   <= dp_next;
        rsi_reg  <= rsi_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        iss_reg  <= iss_next;
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        ok_reg   <= ok_next;
        kok_reg  <= kok_next;
        kval_reg <= kval_next;
        od_reg   <= od_next;
        ou_reg   <= ou_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;

    // checks on the sequencer
    `ASSERT_NEXT(a_acc_scan, clk, rst_n, in_acc, state_reg == S_SCAN)
    `ASSERT_IMPL(a_div_phase, clk, rst_n, div_resp.done,
        state_reg == S_SDIV || state_reg == S_KDIV || state_reg == S_DDIV)
    `ASSERT_IMPL(a_k_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata[14:0] == 15'd0)
    `ASSERT_IMPL(a_d_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[1],
        m_axis_tdata[29:15] == 15'd0)

endmodule

>>> tb/tb.sv
module tb;

    localparam int WATCHDOG_LIMIT = 5000;

    // one result item as the block reports it
    typedef struct packed {
        logic [14:0] k;
        logic [14:0] d;
        logic        kv;
        logic        dv;
    } osc_result_t;

    // directed rows: the expectation is typed in where it is obvious
    typedef struct packed {
        logic [14:0] rsi;
        logic        known;
        osc_result_t res;
    } osc_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [14:0] rsi_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [14:0] stoch_k, [29:15] stoch_d
    logic [1:0]  m_axis_tuser;        // [0] k_valid, [1] d_valid

    stochastic_rsi_oscillator_top u_dut (.*);

    // shadow of the oscillator state
    logic [6:0]  kp_reg;
    logic [4:0]  ks_reg;
    logic [4:0]  dp_reg;
    logic [14:0] rsi_ring [64];
    logic [15:0] stoch_hist [16];
    logic [15:0] k_hist [16];
    logic [5:0]  ring_ptr;
    logic [7:0]  seen_count;

    osc_result_t expected_results [$];
    int          errors = 0;
    int          items_in = 0;
    int          items_out = 0;
    int          flat_seen = 0;
    int          kvalid_seen = 0;
    int          dvalid_seen = 0;
    bit          calm = 0;       // no idling in the last part
    int          stall_left = 0;
    int          idle_cycles = 0;
    logic [14:0] last_rsi = '0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int clamp_len(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // advance the shadow by one sample and give the result it causes
    function automatic osc_result_t predict_oscillator(logic [14:0] rsi);
        int          kp;
        int          ks;
        int          dp;
        int          i;
        int unsigned sum;
        bit          ok;
        logic [14:0] hi;
        logic [14:0] lo;
        logic [14:0] s;
        logic [15:0] entry;
        osc_result_t r;
        kp = clamp_len(kp_reg, srsi_pkg::MAX_K);
        ks = clamp_len(ks_reg, srsi_pkg::MAX_SMOOTH);
        dp = clamp_len(dp_reg, srsi_pkg::MAX_D);
        rsi_ring[ring_ptr] = rsi;
        if (seen_count < srsi_pkg::MAX_K) seen_count++;
        hi = '0;
        lo = '1;
        for (i = 0; i < kp; i++)
        begin
            s = rsi_ring[6'(ring_ptr - i)];
            if (s > hi) hi = s;
            if (s < lo) lo = s;
        end
        ring_ptr++;
        // flat window or warm-up leaves the stoch entry invalid
        if (seen_count >= kp && hi != lo)
            entry = {1'b1, 15'((25600 * (int'(rsi) - int'(lo))) / (int'(hi) - int'(lo)))};
        else
            entry = '0;
        if (hi == lo) flat_seen++;
        for (i = 15; i > 0; i--) stoch_hist[i] = stoch_hist[i-1];
        stoch_hist[0] = entry;
        sum = 0;
        ok = 1;
        for (i = 0; i < ks; i++)
        begin
            if (!stoch_hist[i][15]) ok = 0;
            sum += stoch_hist[i][14:0];
        end
        r.kv = ok;
        r.k  = ok ? 15'(sum / ks) : '0;
        for (i = 15; i > 0; i--) k_hist[i] = k_hist[i-1];
        k_hist[0] = ok ? {1'b1, r.k} : '0;
        sum = 0;
        ok = 1;
        for (i = 0; i < dp; i++)
        begin
            if (!k_hist[i][15]) ok = 0;
            sum += k_hist[i][14:0];
        end
        r.dv = ok;
        r.d  = ok ? 15'(sum / dp) : '0;
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch on item %0d: %s got %0d expected %0d", items_out, what, got, want);
        errors++;
    endtask

    // apb write, setup then access, then the bus is left idle
    task automatic write_reg(srsi_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(4 * idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        case (idx)
            srsi_pkg::REG_K_PERIOD: kp_reg = value[6:0];
            srsi_pkg::REG_K_SMOOTH: ks_reg = value[4:0];
            default:                dp_reg = value[4:0];
        endcase
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(int kp, int ks, int dp);
        write_reg(srsi_pkg::REG_K_PERIOD, kp);
        write_reg(srsi_pkg::REG_K_SMOOTH, ks);
        write_reg(srsi_pkg::REG_D_PERIOD, dp);
    endtask

    // one input item; expectation goes in at the cycle before the accepting edge
    task automatic send_sample(logic [14:0] v, bit known, osc_result_t want);
        osc_result_t p;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, v};
        do @(negedge clk); while (!s_axis_tready);
        p = predict_oscillator(v);
        expected_results.push_back(known ? want : p);
        items_in++;
        last_rsi = v;
        @(posedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    // random samples: flat runs, out-of-range values and the rails mixed in
    function automatic logic [14:0] pick_sample(int hold_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < hold_pct) return last_rsi;
        r = $urandom_range(0, 19);
        if (r == 0) return 15'($urandom_range(25601, 32767));
        if (r == 1) return 15'd0;
        if (r == 2) return 15'd25600;
        return 15'($urandom_range(0, 25600));
    endfunction

    // result side: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // compare each accepted result item against the oldest expectation
    always @(negedge clk)
    begin
        osc_result_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("unexpected result item after %0d items", items_out);
                errors++;
            end
            else
            begin
                w = expected_results.pop_front();
                if (m_axis_tdata[14:0] != w.k)   report("stoch_k", m_axis_tdata[14:0], w.k);
                if (m_axis_tdata[29:15] != w.d)  report("stoch_d", m_axis_tdata[29:15], w.d);
                if (m_axis_tuser[0] != w.kv)     report("k_valid", m_axis_tuser[0], w.kv);
                if (m_axis_tuser[1] != w.dv)     report("d_valid", m_axis_tuser[1], w.dv);
                kvalid_seen += w.kv;
                dvalid_seen += w.dv;
            end
            items_out++;
        end
    end

    // watchdog on cycles without any handshake
    always @(negedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding",
                     expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    osc_row_t directed [16];

    initial
    begin
        int          i;
        int          ph;
        int          n;
        int          hold;
        osc_result_t none;
        none = '0;
        // reset values of the shadow registers
        kp_reg = 7'd14;
        ks_reg = 5'd3;
        dp_reg = 5'd3;
        ring_ptr = '0;
        seen_count = '0;
        for (i = 0; i < 64; i++) rsi_ring[i] = '0;
        for (i = 0; i < 16; i++)
        begin
            stoch_hist[i] = '0;
            k_hist[i] = '0;
        end
        // with a one-sample window every window is flat, so all outputs read zero
        directed[0]  = '{15'd0,     1'b1, none};
        directed[1]  = '{15'd25600, 1'b1, none};
        directed[2]  = '{15'd32767, 1'b1, none};
        directed[3]  = '{15'd1,     1'b1, none};
        directed[4]  = '{15'd25599, 1'b1, none};
        directed[5]  = '{15'd12800, 1'b1, none};
        directed[6]  = '{15'd21845, 1'b1, none};
        directed[7]  = '{15'd10922, 1'b1, none};
        directed[8]  = '{15'd25601, 1'b1, none};
        directed[9]  = '{15'd16384, 1'b1, none};
        directed[10] = '{15'd8192,  1'b1, none};
        directed[11] = '{15'd4096,  1'b1, none};
        directed[12] = '{15'd0,     1'b1, none};
        directed[13] = '{15'd0,     1'b1, none};
        directed[14] = '{15'd25600, 1'b1, none};
        directed[15] = '{15'd32767, 1'b1, none};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero in every register, taken as one; the short window keeps unwritten
        // ring slots out of the scan while the history fills
        set_config(0, 0, 0);
        for (i = 0; i < 16; i++)
            send_sample(directed[i].rsi, directed[i].known, directed[i].res);
        while (items_in < 64)
            send_sample(pick_sample(10), 1'b0, none);
        drain;

        // register settings per phase, extremes first, then random ones
        for (ph = 0; ph < 11; ph++)
        begin
            case (ph)
                0:       set_config(1, 1, 1);
                1:       set_config(64, 16, 16);
                2:       set_config(127, 31, 31);
                3:       set_config(14, 3, 3);
                4:       set_config(2, 16, 1);
                5:       set_config(64, 1, 16);
                default: set_config($urandom_range(0, 127), $urandom_range(0, 31),
                                    $urandom_range(0, 31));
            endcase
            calm = (ph == 10);
            hold = (ph % 3 == 1) ? $urandom_range(40, 95) : $urandom_range(0, 20);
            n = $urandom_range(55, 75);
            for (i = 0; i < n; i++)
                send_sample(pick_sample(hold), 1'b0, none);
            drain;
        end

        repeat (300) @(posedge clk);
        $display("%0d samples sent, %0d results checked over 12 register settings",
                 items_in, items_out);
        $display("%0d flat windows, %0d valid %%K and %0d valid %%D results",
                 flat_seen, kvalid_seen, dvalid_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
